// ===== hw/rtl/egcd_pkg.sv =====
// ----------------------------------------------------------------------------
// egcd_pkg: shared types and constants for the extended gcd block
// Sequencer state type and default operand width.
// ----------------------------------------------------------------------------
`default_nettype none

package egcd_pkg;

	localparam int OPERAND_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPD,
		ST_FINISH
	} egcd_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/egcd_divstep.sv =====
// ----------------------------------------------------------------------------
// egcd_divstep: one restoring-division bit with coefficient accumulation
// Produces one quotient bit and folds it into q*s1 and q*t1 (Horner form).
// ----------------------------------------------------------------------------
`default_nettype none

module egcd_divstep #(
	parameter int OPERAND_WIDTH = 32
) (
	input  wire logic [OPERAND_WIDTH-1:0] rem,
	input  wire logic                     dvd_msb,
	input  wire logic [OPERAND_WIDTH-1:0] divisor,
	input  wire logic [OPERAND_WIDTH+1:0] ps,
	input  wire logic [OPERAND_WIDTH+1:0] pt,
	input  wire logic [OPERAND_WIDTH+1:0] s1,
	input  wire logic [OPERAND_WIDTH+1:0] t1,
	output logic      [OPERAND_WIDTH-1:0] rem_next,
	output logic      [OPERAND_WIDTH+1:0] ps_next,
	output logic      [OPERAND_WIDTH+1:0] pt_next
);
	import egcd_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int CW = OPERAND_WIDTH + 2;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       qbit;

	always_comb begin
		trial    = {rem, dvd_msb};
		diff     = trial - {1'b0, divisor};
		qbit     = (trial >= {1'b0, divisor});
		// remainder stays below divisor, so W bits hold it either way
		rem_next = qbit ? diff[W-1:0] : trial[W-1:0];
		ps_next  = {ps[CW-2:0], 1'b0} + (qbit ? s1 : {CW{1'b0}});
		pt_next  = {pt[CW-2:0], 1'b0} + (qbit ? t1 : {CW{1'b0}});
	end

endmodule

`default_nettype wire

// ===== hw/rtl/extended_euclid_gcd_top.sv =====
// ----------------------------------------------------------------------------
// extended_euclid_gcd_top: extended Euclidean algorithm, gcd and Bezout pair
// Iterative quotient/remainder loop over a shared bit-serial divide unit.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, a, b): one transfer per operand pair.
//    in_ready is high only while the sequencer is idle; one pair is worked
//    on at a time.
//  - Output channel (out_valid/out_ready, gcd_value, coeff_a, coeff_b):
//    one transfer per input, with a*coeff_a + b*coeff_b == gcd_value.
//    b == 0 gives (a, 1, 0); a == 0, b != 0 gives (b, 0, 1).
//  - Each Euclid step runs a check state, restoring division in ST_DIV
//    (one quotient bit per cycle, with q*s1 and q*t1 built alongside) and
//    an update state. For 32-bit operands the loop runs at most 46 steps.
//  - The result sits in an output register, so the next pair is taken while
//    a result still waits. If the receiver stalls and the next result is
//    ready, the sequencer holds in its finish state until the register frees.
//  - Reset (arst_n low) clears the sequencer and the output valid flag; no
//    clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module extended_euclid_gcd_top #(
	parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic        [OPERAND_WIDTH-1:0] a,
	input  wire logic        [OPERAND_WIDTH-1:0] b,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic             [OPERAND_WIDTH-1:0] gcd_value,
	output logic signed      [OPERAND_WIDTH+1:0] coeff_a,
	output logic signed      [OPERAND_WIDTH+1:0] coeff_b
);
	import egcd_pkg::*;

	localparam int W     = OPERAND_WIDTH;
	localparam int CW    = OPERAND_WIDTH + 2;
	localparam int CNT_W = $clog2(OPERAND_WIDTH);

	// sequencer
	egcd_state_t state_q, state_d;

	// remainder pair and coefficient pairs
	logic [W-1:0]  r0_q, r1_q;
	logic [CW-1:0] s0_q, s1_q, t0_q, t1_q;

	// division working registers
	logic [W-1:0]     rem_q, dvd_q;
	logic [CW-1:0]    ps_q, pt_q;
	logic [CNT_W-1:0] cnt_q;

	// output register
	logic          out_valid_q;
	logic [W-1:0]  gcd_q;
	logic [CW-1:0] ca_q, cb_q;

	logic          load_out;
	logic [W-1:0]  rem_next;
	logic [CW-1:0] ps_next, pt_next;

	egcd_divstep #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_divstep (
		.rem     (rem_q),
		.dvd_msb (dvd_q[W-1]),
		.divisor (r1_q),
		.ps      (ps_q),
		.pt      (pt_q),
		.s1      (s1_q),
		.t1      (t1_q),
		.rem_next(rem_next),
		.ps_next (ps_next),
		.pt_next (pt_next)
	);

	// next state and control
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				// zero divisor ends the loop
				state_d = (r1_q == '0) ? ST_FINISH : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0) state_d = ST_UPD;
			end
			ST_UPD: begin
				state_d = ST_CHECK;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					r0_q <= a;
					r1_q <= b;
					s0_q <= CW'(1);
					s1_q <= '0;
					t0_q <= '0;
					t1_q <= CW'(1);
				end
			end
			ST_CHECK: begin
				rem_q <= '0;
				dvd_q <= r0_q;
				ps_q  <= '0;
				pt_q  <= '0;
				cnt_q <= CNT_W'(W - 1);
			end
			ST_DIV: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[W-2:0], 1'b0};
				ps_q  <= ps_next;
				pt_q  <= pt_next;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_UPD: begin
				// (r0,r1) <- (r1, r0 mod r1); coefficients likewise, mod 2^CW
				r0_q <= r1_q;
				r1_q <= rem_q;
				s0_q <= s1_q;
				s1_q <= s0_q - ps_q;
				t0_q <= t1_q;
				t1_q <= t0_q - pt_q;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			gcd_q <= r0_q;
			ca_q  <= s0_q;
			cb_q  <= t0_q;
		end
	end

	assign out_valid = out_valid_q;
	assign gcd_value = gcd_q;
	assign coeff_a   = $signed(ca_q);
	assign coeff_b   = $signed(cb_q);

	// checks
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> r1_q != '0)
		else $error("division started with zero divisor");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < r1_q)
		else $error("partial remainder not below divisor");

	a_finish_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH |-> r1_q == '0)
		else $error("finish reached with nonzero remainder");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before transfer");

endmodule

`default_nettype wire
